// File: src/armt_pkg.sv
package armt_pkg;

   // Channel and sample geometry
   localparam int NUM_CHANNELS = 5;
   localparam int SAMPLE_BITS  = 24;
   localparam int CHID_BITS    = 8;
   localparam int CH_BITS      = 3;
   localparam int KIND_BITS    = 2;
   localparam int THR_BITS     = 11;
   localparam int LANE_BITS    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   // Words in a triggering record: two samples, then max and min of every channel
   localparam int BEATS     = 2 + 2 * NUM_CHANNELS;
   localparam int BEAT_BITS = $clog2(BEATS);

   localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(829);
   localparam logic [THR_BITS-1:0] COUNT_MAX = {THR_BITS{1'b1}};

   // Result word kinds
   localparam logic [KIND_BITS-1:0] KIND_SAMPLE = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_MAX    = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_MIN    = 2'd2;

   typedef logic signed [SAMPLE_BITS-1:0] code_type;

   // One accepted record on its way to the output side
   typedef struct packed {
      logic [CH_BITS-1:0] channel;
      code_type           first_code;
      code_type           second_code;
      logic               stats;
   } entry_type;

   // Per-channel running extremes
   typedef struct packed {
      logic [NUM_CHANNELS-1:0]                  seen;
      logic [NUM_CHANNELS-1:0][SAMPLE_BITS-1:0] max_code;
      logic [NUM_CHANNELS-1:0][SAMPLE_BITS-1:0] min_code;
   } store_type;

endpackage

// File: src/armt_req_if.sv
interface armt_req_if;
   logic                           valid;
   logic                           ready;
   logic [armt_pkg::CHID_BITS-1:0] channel_id;
   armt_pkg::code_type             first_code;
   armt_pkg::code_type             second_code;

   modport source (output valid, output channel_id, output first_code, output second_code,
                   input ready);
   modport sink (input valid, input channel_id, input first_code, input second_code,
                 output ready);
   modport monitor (input valid, input ready, input channel_id, input first_code,
                    input second_code);
endinterface

// File: src/armt_rsp_if.sv
interface armt_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [armt_pkg::KIND_BITS-1:0] kind;
   logic [armt_pkg::CH_BITS-1:0]   channel;
   armt_pkg::code_type             value;
   logic                           last;

   modport source (output valid, output kind, output channel, output value, output last,
                   input ready);
   modport sink (input valid, input kind, input channel, input value, input last,
                 output ready);
   modport monitor (input valid, input ready, input kind, input channel, input value,
                    input last);
endinterface

// File: src/armt_front.sv
module armt_front (
   input  logic                          clock,
   input  logic                          reset,
   armt_req_if.sink                      req_chan,
   input  logic                          csr_wr_en,
   input  logic [armt_pkg::THR_BITS-1:0] csr_wr_data,
   input  logic                          queue_full,
   output logic                          push,
   output armt_pkg::entry_type           push_entry,
   input  logic                          stats_done,
   output armt_pkg::store_type           store
);

   logic [armt_pkg::THR_BITS-1:0]     threshold_ff;
   logic [armt_pkg::THR_BITS-1:0]     count_ff, count_in;
   logic                              hold_ff, hold_in;
   logic [armt_pkg::NUM_CHANNELS-1:0] seen_ff, seen_in;
   logic [armt_pkg::NUM_CHANNELS-1:0][armt_pkg::SAMPLE_BITS-1:0] max_ff, max_in;
   logic [armt_pkg::NUM_CHANNELS-1:0][armt_pkg::SAMPLE_BITS-1:0] min_ff, min_in;

   logic                            accept;
   logic                            valid_ch;
   logic                            trigger;
   logic [armt_pkg::THR_BITS:0]     count_next;
   armt_pkg::code_type              hi_code, lo_code;

   // Take a word unless the queue is full or a statistics burst is pending
   assign req_chan.ready = !queue_full && !hold_ff;
   assign accept         = req_chan.valid && req_chan.ready;
   assign valid_ch       = (req_chan.channel_id != '0) &&
                           (req_chan.channel_id <= armt_pkg::CHID_BITS'(armt_pkg::NUM_CHANNELS));

   // Order the two samples of the record once for all lanes
   assign hi_code = (req_chan.second_code > req_chan.first_code) ?
                    req_chan.second_code : req_chan.first_code;
   assign lo_code = (req_chan.second_code < req_chan.first_code) ?
                    req_chan.second_code : req_chan.first_code;

   // Count two samples per record; the last channel may trigger statistics
   assign count_next = {1'b0, count_ff} + (armt_pkg::THR_BITS + 1)'(2);
   assign trigger    = (req_chan.channel_id == armt_pkg::CHID_BITS'(armt_pkg::NUM_CHANNELS)) &&
                       (count_next > {1'b0, threshold_ff});

   assign push                   = accept && valid_ch;
   assign push_entry.channel     = req_chan.channel_id[armt_pkg::CH_BITS-1:0];
   assign push_entry.first_code  = req_chan.first_code;
   assign push_entry.second_code = req_chan.second_code;
   assign push_entry.stats       = trigger;

   // Update each lane against its own extremes
   always_comb begin
      seen_in = seen_ff;
      max_in  = max_ff;
      min_in  = min_ff;
      for (int l = 0; l < armt_pkg::NUM_CHANNELS; l++) begin
         if (push && (req_chan.channel_id == armt_pkg::CHID_BITS'(l + 1))) begin
            seen_in[l] = 1'b1;
            if (!seen_ff[l]) begin
               max_in[l] = hi_code;
               min_in[l] = lo_code;
            end else begin
               if (hi_code > armt_pkg::code_type'(max_ff[l])) max_in[l] = hi_code;
               if (lo_code < armt_pkg::code_type'(min_ff[l])) min_in[l] = lo_code;
            end
         end
      end
   end

   // Advance the count, clear it on a burst, saturate it at its maximum
   always_comb begin
      count_in = count_ff;
      hold_in  = hold_ff;
      if (push) begin
         if (trigger) begin
            count_in = '0;
            hold_in  = 1'b1;
         end else if (count_next[armt_pkg::THR_BITS]) begin
            count_in = armt_pkg::COUNT_MAX;
         end else begin
            count_in = count_next[armt_pkg::THR_BITS-1:0];
         end
      end else if (stats_done) begin
         hold_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= armt_pkg::THR_RESET;
         count_ff     <= '0;
         hold_ff      <= 1'b0;
         seen_ff      <= '0;
      end else begin
         if (csr_wr_en) threshold_ff <= csr_wr_data;
         count_ff <= count_in;
         hold_ff  <= hold_in;
         seen_ff  <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      max_ff <= max_in;
      min_ff <= min_in;
   end

   assign store.seen     = seen_ff;
   assign store.max_code = max_ff;
   assign store.min_code = min_ff;

endmodule

// File: src/armt_queue.sv
module armt_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  armt_pkg::entry_type push_entry,
   input  logic                pop,
   output armt_pkg::entry_type head,
   output logic                full,
   output logic                empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   armt_pkg::entry_type       slots_ff [DEPTH];
   logic [PTR_BITS-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [PTR_BITS:0]         fill_ff;

   function automatic logic [PTR_BITS-1:0] wrap_inc(input logic [PTR_BITS-1:0] p);
      logic [PTR_BITS-1:0] r;
      if (p == PTR_BITS'(DEPTH - 1)) r = '0;
      else                           r = p + 1'b1;
      return r;
   endfunction

   assign full  = (fill_ff == (PTR_BITS + 1)'(DEPTH));
   assign empty = (fill_ff == '0);
   assign head  = slots_ff[rd_ptr_ff];

   // Hold the words in order
   always_ff @(posedge clock) begin
      if (push) slots_ff[wr_ptr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) wr_ptr_ff <= wrap_inc(wr_ptr_ff);
         if (pop)  rd_ptr_ff <= wrap_inc(rd_ptr_ff);
         if (push && !pop)      fill_ff <= fill_ff + 1'b1;
         else if (pop && !push) fill_ff <= fill_ff - 1'b1;
      end
   end

endmodule

// File: src/armt_back.sv
module armt_back (
   input  logic                clock,
   input  logic                reset,
   input  armt_pkg::entry_type head,
   input  logic                empty,
   input  armt_pkg::store_type store,
   output logic                pop,
   output logic                stats_done,
   armt_rsp_if.source          rsp_chan
);

   logic [armt_pkg::BEAT_BITS-1:0] beat_ff;
   logic                           valid_ff;
   logic [armt_pkg::KIND_BITS-1:0] kind_ff, kind_in;
   logic [armt_pkg::CH_BITS-1:0]   channel_ff, channel_in;
   armt_pkg::code_type             value_ff, value_in;
   logic                           last_ff, last_in;

   logic                           load;
   logic [armt_pkg::BEAT_BITS-1:0] stat_idx;
   logic [armt_pkg::LANE_BITS-1:0] lane;

   // Fill the output register whenever it is empty or being taken
   assign load     = !empty && (!valid_ff || rsp_chan.ready);
   assign stat_idx = beat_ff - armt_pkg::BEAT_BITS'(2);
   assign lane     = armt_pkg::LANE_BITS'(stat_idx >> 1);

   // Build the next word from the head record and the extremes
   always_comb begin
      kind_in    = armt_pkg::KIND_SAMPLE;
      channel_in = head.channel;
      value_in   = head.first_code;
      last_in    = 1'b0;
      case (beat_ff)
         armt_pkg::BEAT_BITS'(0): begin
            value_in = head.first_code;
         end
         armt_pkg::BEAT_BITS'(1): begin
            value_in = head.second_code;
            last_in  = !head.stats;
         end
         default: begin
            kind_in    = stat_idx[0] ? armt_pkg::KIND_MIN : armt_pkg::KIND_MAX;
            channel_in = armt_pkg::CH_BITS'(lane) + 1'b1;
            if (!store.seen[lane])  value_in = '0;
            else if (stat_idx[0])   value_in = store.min_code[lane];
            else                    value_in = store.max_code[lane];
            last_in    = (beat_ff == armt_pkg::BEAT_BITS'(armt_pkg::BEATS - 1));
         end
      endcase
   end

   assign pop        = load && last_in;
   assign stats_done = pop && head.stats;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         beat_ff  <= '0;
      end else begin
         if (load)                 valid_ff <= 1'b1;
         else if (rsp_chan.ready)  valid_ff <= 1'b0;
         if (load) begin
            if (last_in) beat_ff <= '0;
            else         beat_ff <= beat_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff    <= kind_in;
         channel_ff <= channel_in;
         value_ff   <= value_in;
         last_ff    <= last_in;
      end
   end

   assign rsp_chan.valid   = valid_ff;
   assign rsp_chan.kind    = kind_ff;
   assign rsp_chan.channel = channel_ff;
   assign rsp_chan.value   = value_ff;
   assign rsp_chan.last    = last_ff;

endmodule

// File: src/adc_record_minmax_tracker.sv
// A record's first word passes the queue slot, then the output register (empty queue, no stall).
// The output register emits one word a cycle while the result side is ready; a record gives
// two sample words, a triggering record adds ten statistics words, and intake pauses until they go.
// The input side takes a record each cycle while the queue between the sides has room.
// Reset (synchronous, active high) clears count, seen flags and queue; threshold to 829.
module adc_record_minmax_tracker #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   armt_req_if.sink                      req_chan,
   armt_rsp_if.source                    rsp_chan,
   input  logic                          csr_wr_en,
   input  logic [armt_pkg::THR_BITS-1:0] csr_wr_data
);

   logic                queue_full, queue_empty;
   logic                push, pop, stats_done;
   armt_pkg::entry_type push_entry, head;
   armt_pkg::store_type store;

   // Classify, count and track extremes
   armt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .queue_full  (queue_full),
      .push        (push),
      .push_entry  (push_entry),
      .stats_done  (stats_done),
      .store       (store)
   );

   // Decouple intake from output
   armt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .full       (queue_full),
      .empty      (queue_empty)
   );

   // Serialise each record into words
   armt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .empty      (queue_empty),
      .store      (store),
      .pop        (pop),
      .stats_done (stats_done),
      .rsp_chan   (rsp_chan)
   );

endmodule

// File: src/armt_checker.sv
module armt_checker (
   input  logic         clock,
   input  logic         reset,
   armt_req_if.sink     req_chan,
   armt_rsp_if.source   rsp_chan
);

   // A waiting request word holds
   assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && !req_chan.ready |=> req_chan.valid && $stable(req_chan.channel_id) &&
      $stable(req_chan.first_code) && $stable(req_chan.second_code))
      else $error("waiting request word changed");

   // A stalled word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=> rsp_chan.valid && $stable(rsp_chan.value) &&
      $stable(rsp_chan.kind) && $stable(rsp_chan.channel) && $stable(rsp_chan.last))
      else $error("stalled result word changed");

   // Nothing leaves straight after reset
   assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("result valid after reset");

   // Words carry a real channel and kind
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.channel != '0 &&
      rsp_chan.channel <= armt_pkg::CH_BITS'(armt_pkg::NUM_CHANNELS) &&
      (rsp_chan.kind == armt_pkg::KIND_SAMPLE || rsp_chan.kind == armt_pkg::KIND_MAX ||
       rsp_chan.kind == armt_pkg::KIND_MIN))
      else $error("bad channel or kind");

   // A statistics burst ends on the last channel's minimum
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.last && rsp_chan.kind != armt_pkg::KIND_SAMPLE |->
      rsp_chan.kind == armt_pkg::KIND_MIN &&
      rsp_chan.channel == armt_pkg::CH_BITS'(armt_pkg::NUM_CHANNELS))
      else $error("statistics burst ended early");

endmodule

bind adc_record_minmax_tracker armt_checker u_armt_checker (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan)
);

// File: tb/record_stats_checker.sv
module record_stats_checker (
   input  logic                          clock,
   input  logic                          reset,
   armt_req_if.monitor                   req,
   armt_rsp_if.monitor                   rsp,
   input  logic                          csr_wr_en,
   input  logic [armt_pkg::THR_BITS-1:0] csr_wr_data,
   output int                            fail_count,
   output int                            words_pending
);

   localparam int MAX_REPORTS = 100;

   typedef struct packed {
      logic [armt_pkg::KIND_BITS-1:0] kind;
      logic [armt_pkg::CH_BITS-1:0]   channel;
      armt_pkg::code_type             value;
      logic                           last;
   } word_type;

   word_type                      expected_words[$];
   armt_pkg::code_type            peak_code   [1:armt_pkg::NUM_CHANNELS];
   armt_pkg::code_type            trough_code [1:armt_pkg::NUM_CHANNELS];
   logic                          seen        [1:armt_pkg::NUM_CHANNELS];
   logic [armt_pkg::THR_BITS-1:0] sample_total;
   logic [armt_pkg::THR_BITS-1:0] threshold;
   int                            errors  = 0;
   int                            reports = 0;

   function automatic word_type make_word(input logic [armt_pkg::KIND_BITS-1:0] kind,
                                          input int ch, input armt_pkg::code_type value,
                                          input logic last);
      word_type w;
      w.kind    = kind;
      w.channel = armt_pkg::CH_BITS'(ch);
      w.value   = value;
      w.last    = last;
      return w;
   endfunction

   // Return the extremes, counters and pending words to their power-up state
   task automatic clear_tracker();
      int c;
      for (c = 1; c <= armt_pkg::NUM_CHANNELS; c++) begin
         peak_code[c]   = '0;
         trough_code[c] = '0;
         seen[c]        = 1'b0;
      end
      sample_total = '0;
      threshold    = armt_pkg::THR_RESET;
      expected_words.delete();
   endtask

   // Fold one sample into its channel's running max and min
   task automatic track_extremes(input int ch, input armt_pkg::code_type sample);
      if (!seen[ch]) begin
         peak_code[ch]   = sample;
         trough_code[ch] = sample;
         seen[ch]        = 1'b1;
      end
      if (sample > peak_code[ch]) peak_code[ch] = sample;
      if (sample < trough_code[ch]) trough_code[ch] = sample;
   endtask

   // Work out the words one record causes and queue them in order
   task automatic predict_record(input logic [armt_pkg::CHID_BITS-1:0] chid,
                                 input armt_pkg::code_type first_code,
                                 input armt_pkg::code_type second_code);
      int                          ch;
      int                          c;
      logic [armt_pkg::THR_BITS:0] next_total;
      logic                        stats_due;
      ch = int'(chid);
      if (ch < 1 || ch > armt_pkg::NUM_CHANNELS) return;
      // the sum is compared one bit wider, so a full threshold still trips
      next_total = {1'b0, sample_total} + (armt_pkg::THR_BITS + 1)'(2);
      stats_due  = (ch == armt_pkg::NUM_CHANNELS) && (next_total > {1'b0, threshold});
      track_extremes(ch, first_code);
      expected_words.push_back(make_word(armt_pkg::KIND_SAMPLE, ch, first_code, 1'b0));
      track_extremes(ch, second_code);
      expected_words.push_back(make_word(armt_pkg::KIND_SAMPLE, ch, second_code, !stats_due));
      if (stats_due) begin
         // unseen channels report zero for both extremes
         for (c = 1; c <= armt_pkg::NUM_CHANNELS; c++) begin
            expected_words.push_back(make_word(armt_pkg::KIND_MAX, c, peak_code[c], 1'b0));
            expected_words.push_back(make_word(armt_pkg::KIND_MIN, c, trough_code[c],
                                               c == armt_pkg::NUM_CHANNELS));
         end
         sample_total = '0;
      end else if (next_total > {1'b0, armt_pkg::COUNT_MAX}) begin
         sample_total = armt_pkg::COUNT_MAX;
      end else begin
         sample_total = next_total[armt_pkg::THR_BITS-1:0];
      end
   endtask

   // Compare an accepted word with the oldest one waiting
   task automatic check_word(input word_type got);
      word_type want;
      if (expected_words.size() == 0) begin
         errors++;
         if (reports < MAX_REPORTS) begin
            $display("%0t: unexpected word: kind=%0d channel=%0d value=%h last=%b",
                     $time, got.kind, got.channel, got.value, got.last);
            reports++;
         end
         return;
      end
      want = expected_words.pop_front();
      if (got !== want) begin
         errors++;
         if (reports < MAX_REPORTS) begin
            $display({"%0t: word mismatch: expected kind=%0d channel=%0d value=%h last=%b,",
                      " actual kind=%0d channel=%0d value=%h last=%b"},
                     $time, want.kind, want.channel, want.value, want.last,
                     got.kind, got.channel, got.value, got.last);
            reports++;
         end
      end
   endtask

   // Watch both channels and the register port at each edge
   always @(posedge clock) begin
      if (reset) begin
         clear_tracker();
      end else begin
         if (csr_wr_en) threshold = csr_wr_data;
         if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
            check_word({rsp.kind, rsp.channel, rsp.value, rsp.last});
         end
         if (req.valid === 1'b1 && req.ready === 1'b1) begin
            predict_record(req.channel_id, req.first_code, req.second_code);
         end
      end
      words_pending <= expected_words.size();
      fail_count    <= errors;
   end

endmodule

// File: tb/testbench.sv
module testbench;

   localparam int                 IDLE_LIMIT    = 2000;
   localparam int                 SETTLE_CYCLES = 16;
   localparam armt_pkg::code_type CODE_HIGH =
      {1'b0, {(armt_pkg::SAMPLE_BITS-1){1'b1}}};
   localparam armt_pkg::code_type CODE_LOW  =
      {1'b1, {(armt_pkg::SAMPLE_BITS-1){1'b0}}};
   localparam logic [armt_pkg::CHID_BITS-1:0] LAST_CHANNEL =
      armt_pkg::CHID_BITS'(armt_pkg::NUM_CHANNELS);

   typedef enum logic [1:0] {DRAIN_FREE, DRAIN_COIN, DRAIN_SPARSE, DRAIN_HELD} drain_mode_type;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          csr_wr_en;
   logic [armt_pkg::THR_BITS-1:0] csr_wr_data;
   int                            fail_count;
   int                            words_pending;
   int                            burst_left  = 0;
   int                            idle_cycles = 0;
   drain_mode_type                drain_mode  = DRAIN_FREE;
   int                            drain_left  = 0;
   int                            drain_phase = 0;

   armt_req_if req_bus();
   armt_rsp_if rsp_bus();

   adc_record_minmax_tracker dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   record_stats_checker stats_check (
      .clock         (clock),
      .reset         (reset),
      .req           (req_bus),
      .rsp           (rsp_bus),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .words_pending (words_pending)
   );

   always #1 clock = ~clock;

   // Stall the result side in stretches of varying pattern
   always @(posedge clock) begin
      int pick;
      if (drain_left == 0) begin
         pick       = $urandom_range(0, 7);
         drain_mode = (pick < 4) ? DRAIN_FREE : (pick < 6) ? DRAIN_COIN :
                      (pick == 6) ? DRAIN_SPARSE : DRAIN_HELD;
         drain_left = (drain_mode == DRAIN_HELD) ? $urandom_range(2, 12) :
                                                   $urandom_range(8, 60);
      end else begin
         drain_left--;
      end
      drain_phase++;
      case (drain_mode)
         DRAIN_FREE:   rsp_bus.ready <= 1'b1;
         DRAIN_COIN:   rsp_bus.ready <= 1'($urandom_range(0, 1));
         DRAIN_SPARSE: rsp_bus.ready <= (drain_phase % 5 == 0);
         default:      rsp_bus.ready <= 1'b0;
      endcase
   end

   // End the run when no word moves for too long
   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("** adc_record_minmax_tracker: FAILED **");
         $finish;
      end
   end

   // Offer one record, with a random gap at the start of each burst
   task automatic send_record(input logic [armt_pkg::CHID_BITS-1:0] chid,
                              input armt_pkg::code_type first_code,
                              input armt_pkg::code_type second_code);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid       <= 1'b1;
      req_bus.channel_id  <= chid;
      req_bus.first_code  <= first_code;
      req_bus.second_code <= second_code;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   // Mostly extremes and small values near zero, the rest full-range
   function automatic armt_pkg::code_type random_code();
      case ($urandom_range(0, 7))
         0:       return CODE_HIGH;
         1:       return CODE_LOW;
         2:       return '0;
         3:       return '1;
         4, 5:    return armt_pkg::code_type'(int'($urandom_range(0, 64)) - 32);
         default: return armt_pkg::code_type'($urandom());
      endcase
   endfunction

   // Valid channels up to top_channel, with the odd invalid byte mixed in
   function automatic logic [armt_pkg::CHID_BITS-1:0] random_channel(input int top_channel);
      if ($urandom_range(0, 9) == 0) begin
         if ($urandom_range(0, 1) == 0) return '0;
         return armt_pkg::CHID_BITS'($urandom_range(armt_pkg::NUM_CHANNELS + 1, 255));
      end
      return armt_pkg::CHID_BITS'($urandom_range(1, top_channel));
   endfunction

   // Send records until valid_count of them carried a valid channel
   task automatic send_random_records(input int valid_count, input int top_channel);
      logic [armt_pkg::CHID_BITS-1:0] chid;
      int                             sent;
      sent = 0;
      while (sent < valid_count) begin
         chid = random_channel(top_channel);
         send_record(chid, random_code(), random_code());
         if (chid >= 1 && chid <= armt_pkg::NUM_CHANNELS) sent++;
      end
   endtask

   // Drop valid and wait for every expected word, plus time for dropped records
   task automatic hold_until_drained();
      req_bus.valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [armt_pkg::THR_BITS-1:0] value);
      hold_until_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      reset               <= 1'b1;
      csr_wr_en           <= 1'b0;
      csr_wr_data         <= '0;
      req_bus.valid       <= 1'b0;
      req_bus.channel_id  <= '0;
      req_bus.first_code  <= '0;
      req_bus.second_code <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed records at the reset threshold; channel 4 stays untouched
      send_record(8'd1, CODE_HIGH, CODE_LOW);
      send_record(8'd1, '0, '0);
      send_record(8'd2, 24'sd5, 24'sd5);
      send_record(8'd2, 24'sd5, -24'sd5);
      send_record(8'd2, -24'sd5, -24'sd5);
      send_record(8'd3, CODE_LOW, CODE_LOW);
      send_record(8'd3, CODE_HIGH, '1);
      send_record(8'd0, 24'h000123, 24'h000456);
      send_record(8'd6, CODE_HIGH, CODE_HIGH);
      send_record(8'd255, CODE_LOW, '1);
      send_record(8'hAA, 24'h555555, 24'hAAAAAA);
      send_record(8'h55, 24'hAAAAAA, 24'h555555);
      send_record(LAST_CHANNEL, 24'sd1, -24'sd1);
      send_record(LAST_CHANNEL, 24'h400000, 24'hC00000);
      send_record(8'd3, 24'h000001, 24'hFFFFFF);
      send_record(8'd1, 24'h123456, 24'hEDCBA9);

      // Zero threshold: report at once with channel 4 unseen, then on every last channel
      write_threshold('0);
      send_record(LAST_CHANNEL, random_code(), random_code());
      send_random_records(20, armt_pkg::NUM_CHANNELS);

      // Random phases over a spread of thresholds
      write_threshold(armt_pkg::THR_BITS'($urandom_range(1, 16)));
      send_random_records(30, armt_pkg::NUM_CHANNELS);
      write_threshold(armt_pkg::THR_BITS'(2));
      send_random_records(20, armt_pkg::NUM_CHANNELS);
      write_threshold(armt_pkg::THR_BITS'($urandom_range(17, 60)));
      send_random_records(40, armt_pkg::NUM_CHANNELS);
      write_threshold(armt_pkg::THR_BITS'($urandom_range(3, 10)));
      send_random_records(25, armt_pkg::NUM_CHANNELS);

      hold_until_drained();
      if (fail_count == 0 && words_pending == 0) begin
         $display("** adc_record_minmax_tracker: PASSED **");
      end else begin
         $display("** adc_record_minmax_tracker: FAILED **");
      end
      $finish;
   end

endmodule
